// ----- sv/ohs_pkg.sv -----
// Shared types and constants for the octant heading steer block.
`default_nettype none

package ohs_pkg;

    // Fixed field widths
    localparam int OCT_W      = 14;
    localparam int HEAD_W     = 16;
    localparam int BEAR_W     = 16;
    localparam int ACT_W      = 2;
    localparam int SUM_W      = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int OUT_DATA_W = ((BEAR_W + ACT_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [OCT_W-1:0] OCT_RESET = 14'd6390;
    localparam logic [OCT_W-1:0] DB_RESET  = 14'd1638;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OCTANT   = 1'b0,
        CFG_DEADBAND = 1'b1
    } t_cfg_idx;

    // Steering commands
    typedef enum logic [ACT_W-1:0] {
        TURN_RIGHT = 2'd0,
        TURN_LEFT  = 2'd1,
        STOP_RIGHT = 2'd2,
        STOP_LEFT  = 2'd3
    } t_turn;

    // How the ratio term joins the octant base angle
    typedef enum logic [1:0] {
        FOP_NONE,
        FOP_ADD,
        FOP_SUB
    } t_fop;

    // Operations of the shared difference unit
    typedef enum logic [2:0] {
        DOP_SUBX,
        DOP_SUBY,
        DOP_ABSX,
        DOP_ABSY,
        DOP_CMP
    } t_dop;

    typedef struct packed {
        logic en;
        t_dop op;
    } t_dctl;

    // Signs, zero flags and magnitude order of the position difference
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
        logic ax_gt;
        logic ax_lt;
    } t_geom;

    // Multiply/divide unit sequencer
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

    // Top-level sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SUBX,
        S_SUBY,
        S_ABSX,
        S_ABSY,
        S_CMP,
        S_MDGO,
        S_MDWAIT,
        S_STWAIT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/octant_heading_steer_core.sv -----
// Octant heading steer: bearing toward a target and a turn command per position beat.
//
// Input stream (i_s_*): one beat carries own and target positions and the current heading.
// Output stream (o_m_*): one beat per input with the approximated bearing and turn command.
// Configuration: i_cfg_we writes i_cfg_data into octant_angle (index 0) or
// turn_deadband (index 1); write only while no beat is in progress.
// An item passes in order through the shared difference subtractor (x and y differences,
// their magnitudes and their compare), a start state for the bit-serial multiply/divide
// unit with its 14 shift-add steps and 14 restoring division steps, the three steer
// stages, a wait state, the emit state that loads the output register and the idle
// state in which the next input beat is taken; o_m_tvalid comes from the output register.
// One item is in flight at a time; the result sits in an output register, so a new
// input beat is taken while an earlier result still waits for i_m_tready. If the next
// result is ready while the output register is still full, the block holds it until
// the receiver takes the waiting beat.
// Reset (synchronous, active low) restores the default register values, clears the
// remembered turn to right and empties the output register.
`default_nettype none

module octant_heading_steer_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 13,
    localparam int IN_DATA_W      = ((4 * COORD_WIDTH + ohs_pkg::HEAD_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [ohs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ohs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // Fields from bit 0: own_x, own_y, target_x, target_y, heading, zero pad
    input  logic [IN_DATA_W-1:0]            i_s_tdata,
    // Output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // Fields from bit 0: bearing, turn_action, zero pad
    output logic [ohs_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import ohs_pkg::*;

    localparam int CW = COORD_WIDTH;

    t_state             r_state, n_state;
    logic [OCT_W-1:0]   r_oct, r_db;
    logic               r_last_turn;
    logic [CW-1:0]      r_own_x, r_own_y, r_target_x, r_target_y;
    logic [HEAD_W-1:0]  r_heading;
    logic               r_out_valid;
    logic [BEAR_W-1:0]  r_out_bear;
    logic [ACT_W-1:0]   r_out_act;

    t_dctl              w_dctl;
    logic               w_md_start, w_md_done, w_st_done, w_load;
    logic [CW-1:0]      w_ax, w_ay, w_small, w_large;
    t_geom              w_geom;
    logic [OCT_W-1:0]   w_quo;
    logic [BEAR_W-1:0]  w_bear;
    t_turn              w_act;

    assign o_s_tready = (r_state == S_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct <= OCT_RESET;
            r_db  <= DB_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OCTANT:   r_oct <= i_cfg_data;
                CFG_DEADBAND: r_db  <= i_cfg_data;
                default:      r_oct <= r_oct;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_own_x    <= i_s_tdata[CW-1:0];
            r_own_y    <= i_s_tdata[2*CW-1:CW];
            r_target_x <= i_s_tdata[3*CW-1:2*CW];
            r_target_y <= i_s_tdata[4*CW-1:3*CW];
            r_heading  <= i_s_tdata[4*CW+HEAD_W-1:4*CW];
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and controls
    always_comb begin
        n_state    = r_state;
        w_dctl     = '{en: 1'b0, op: DOP_SUBX};
        w_md_start = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_SUBX;
                end
            end
            S_SUBX: begin
                w_dctl  = '{en: 1'b1, op: DOP_SUBX};
                n_state = S_SUBY;
            end
            S_SUBY: begin
                w_dctl  = '{en: 1'b1, op: DOP_SUBY};
                n_state = S_ABSX;
            end
            S_ABSX: begin
                w_dctl  = '{en: 1'b1, op: DOP_ABSX};
                n_state = S_ABSY;
            end
            S_ABSY: begin
                w_dctl  = '{en: 1'b1, op: DOP_ABSY};
                n_state = S_CMP;
            end
            S_CMP: begin
                w_dctl  = '{en: 1'b1, op: DOP_CMP};
                n_state = S_MDGO;
            end
            S_MDGO: begin
                w_md_start = 1'b1;
                n_state    = S_MDWAIT;
            end
            S_MDWAIT: begin
                if (w_md_done) begin
                    n_state = S_STWAIT;
                end
            end
            S_STWAIT: begin
                if (w_st_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    ohs_delta #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_delta (
        .i_clk      (i_clk),
        .i_ctl      (w_dctl),
        .i_own_x    (r_own_x),
        .i_own_y    (r_own_y),
        .i_target_x (r_target_x),
        .i_target_y (r_target_y),
        .o_ax       (w_ax),
        .o_ay       (w_ay),
        .o_geom     (w_geom)
    );

    // The smaller magnitude over the larger one
    assign w_small = w_geom.ax_gt ? w_ay : w_ax;
    assign w_large = w_geom.ax_gt ? w_ax : w_ay;

    ohs_muldiv #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_small (w_small),
        .i_large (w_large),
        .i_oct   (r_oct),
        .o_done  (w_md_done),
        .o_quo   (w_quo)
    );

    ohs_steer #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_steer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_md_done),
        .i_geom      (w_geom),
        .i_quo       (w_quo),
        .i_oct       (r_oct),
        .i_deadband  (r_db),
        .i_heading   (r_heading),
        .i_last_turn (r_last_turn),
        .o_done      (w_st_done),
        .o_bearing   (w_bear),
        .o_action    (w_act)
    );

    // Output register and remembered turn direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_turn <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load && (w_act == TURN_RIGHT)) begin
                r_last_turn <= 1'b0;
            end else if (w_load && (w_act == TURN_LEFT)) begin
                r_last_turn <= 1'b1;
            end
        end
        if (w_load) begin
            r_out_bear <= w_bear;
            r_out_act  <= w_act;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - BEAR_W - ACT_W){1'b0}}, r_out_act, r_out_bear};

    // The divider finishes only while the sequencer waits for it
    a_md_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == S_MDWAIT))
        else $error("divider finished outside its wait state");

    // The steer stages finish only while the sequencer waits for them
    a_st_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st_done |-> (r_state == S_STWAIT))
        else $error("steer stages finished outside their wait state");

    // A waiting output beat is never overwritten by the next result
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_m_tready) |=> (r_state == S_EMIT))
        else $error("result left the emit state while the output beat was stalled");

    // A stop command leaves the remembered turn unchanged
    a_stop_keeps_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_act == STOP_RIGHT || w_act == STOP_LEFT)) |=> $stable(r_last_turn))
        else $error("stop command changed the remembered turn");

endmodule

`default_nettype wire

// ----- sv/ohs_delta.sv -----
// Shared subtractor that forms the position differences, their magnitudes and their order.
`default_nettype none

module ohs_delta #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  ohs_pkg::t_dctl         i_ctl,
    input  logic [COORD_WIDTH-1:0] i_own_x,
    input  logic [COORD_WIDTH-1:0] i_own_y,
    input  logic [COORD_WIDTH-1:0] i_target_x,
    input  logic [COORD_WIDTH-1:0] i_target_y,
    output logic [COORD_WIDTH-1:0] o_ax,
    output logic [COORD_WIDTH-1:0] o_ay,
    output ohs_pkg::t_geom          o_geom
);
    import ohs_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic [DW-1:0] r_dx, n_dx;
    logic [DW-1:0] r_dy, n_dy;
    t_geom         r_geom, n_geom;
    logic [DW-1:0] w_p, w_q, w_diff;

    // Operand selection for the one subtractor
    always_comb begin
        w_p = '0;
        w_q = '0;
        case (i_ctl.op)
            DOP_SUBX: begin
                w_p = {i_target_x[COORD_WIDTH-1], i_target_x};
                w_q = {i_own_x[COORD_WIDTH-1], i_own_x};
            end
            DOP_SUBY: begin
                w_p = {i_target_y[COORD_WIDTH-1], i_target_y};
                w_q = {i_own_y[COORD_WIDTH-1], i_own_y};
            end
            DOP_ABSX: begin
                w_p = r_dx[DW-1] ? '0 : r_dx;
                w_q = r_dx[DW-1] ? r_dx : '0;
            end
            DOP_ABSY: begin
                w_p = r_dy[DW-1] ? '0 : r_dy;
                w_q = r_dy[DW-1] ? r_dy : '0;
            end
            DOP_CMP: begin
                w_p = r_dx;
                w_q = r_dy;
            end
            default: begin
                w_p = '0;
                w_q = '0;
            end
        endcase
        w_diff = w_p - w_q;
    end

    // Result steering; the magnitude compare only records the order
    always_comb begin
        n_dx   = r_dx;
        n_dy   = r_dy;
        n_geom = r_geom;
        if (i_ctl.en) begin
            case (i_ctl.op)
                DOP_SUBX: n_dx = w_diff;
                DOP_SUBY: n_dy = w_diff;
                DOP_ABSX: begin
                    n_dx          = w_diff;
                    n_geom.x_neg  = r_dx[DW-1];
                    n_geom.x_zero = (r_dx == '0);
                end
                DOP_ABSY: begin
                    n_dy          = w_diff;
                    n_geom.y_neg  = r_dy[DW-1];
                    n_geom.y_zero = (r_dy == '0);
                end
                DOP_CMP: begin
                    n_geom.ax_lt = w_diff[DW-1];
                    n_geom.ax_gt = !w_diff[DW-1] && (w_diff != '0);
                end
                default: n_dx = r_dx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_geom <= n_geom;
    end

    assign o_ax   = r_dx[COORD_WIDTH-1:0];
    assign o_ay   = r_dy[COORD_WIDTH-1:0];
    assign o_geom = r_geom;

endmodule

`default_nettype wire

// ----- sv/ohs_muldiv.sv -----
// Bit-serial unit that forms floor(small * octant_angle / large), one bit per cycle.
`default_nettype none

module ohs_muldiv #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [COORD_WIDTH-1:0]     i_small,
    input  logic [COORD_WIDTH-1:0]     i_large,
    input  logic [ohs_pkg::OCT_W-1:0]  i_oct,
    output logic                       o_done,
    output logic [ohs_pkg::OCT_W-1:0]  o_quo
);
    import ohs_pkg::*;

    localparam int NW    = COORD_WIDTH + OCT_W;
    localparam int CNT_W = $clog2(OCT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OCT_W - 1);

    t_md_state              r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_done, n_done;
    logic [NW-1:0]          r_acc, n_acc;
    logic [OCT_W-1:0]       r_mul, n_mul;
    logic [COORD_WIDTH-1:0] r_rem, n_rem;
    logic [OCT_W-1:0]       r_quo, n_quo;
    logic [NW-1:0]          w_acc_sum;
    logic [COORD_WIDTH:0]   w_trial, w_diffd;
    logic                   w_ge;

    // Shift-and-add product, multiplier bits taken MSB first
    assign w_acc_sum = {r_acc[NW-2:0], 1'b0} + (r_mul[OCT_W-1] ? NW'(i_small) : '0);

    // Restoring division step: the next numerator bit sits at the top of r_quo
    assign w_trial = {r_rem, r_quo[OCT_W-1]};
    assign w_diffd = w_trial - {1'b0, i_large};
    assign w_ge    = !w_diffd[COORD_WIDTH];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_mul   = r_mul;
        n_rem   = r_rem;
        n_quo   = r_quo;
        case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    n_state = MD_MUL;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_mul   = i_oct;
                end
            end
            MD_MUL: begin
                n_acc = w_acc_sum;
                n_mul = {r_mul[OCT_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    // The quotient fits OCT_W bits, so the upper product bits
                    // already form the first partial remainder.
                    n_state = MD_DIV;
                    n_cnt   = '0;
                    n_rem   = w_acc_sum[NW-1:OCT_W];
                    n_quo   = w_acc_sum[OCT_W-1:0];
                end
            end
            MD_DIV: begin
                n_rem = w_ge ? w_diffd[COORD_WIDTH-1:0] : w_trial[COORD_WIDTH-1:0];
                n_quo = {r_quo[OCT_W-2:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = MD_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_acc <= n_acc;
        r_mul <= n_mul;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ----- sv/ohs_steer.sv -----
// Bearing assembly from octant base and ratio term, saturation and turn decision.
`default_nettype none

module ohs_steer #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ohs_pkg::t_geom              i_geom,
    input  logic [ohs_pkg::OCT_W-1:0]   i_quo,
    input  logic [ohs_pkg::OCT_W-1:0]   i_oct,
    input  logic [ohs_pkg::OCT_W-1:0]   i_deadband,
    input  logic [ohs_pkg::HEAD_W-1:0]  i_heading,
    input  logic                        i_last_turn,
    output logic                        o_done,
    output logic [ohs_pkg::BEAR_W-1:0]  o_bearing,
    output ohs_pkg::t_turn              o_action
);
    import ohs_pkg::*;

    localparam int BEAR_FULL = (1 << (ANGLE_FRAC_BITS + 3)) - 1;
    localparam int BEAR_TOP  = (1 << BEAR_W) - 1;
    localparam logic [SUM_W-1:0] BEAR_LIM =
        SUM_W'((BEAR_FULL < BEAR_TOP) ? BEAR_FULL : BEAR_TOP);

    logic [2:0]        r_vld;
    logic [SUM_W-1:0]  r_base;
    t_fop              r_fop;
    logic [BEAR_W-1:0] r_bear;
    logic [BEAR_W-1:0] r_err;
    logic              r_hgt;

    logic [3:0]        w_mult;
    t_fop              w_fop;
    logic [SUM_W-1:0]  w_prod, w_sum;
    logic [BEAR_W-1:0] w_half;

    // Octant base multiple and the sign of the ratio term
    always_comb begin
        w_mult = 4'd0;
        w_fop  = FOP_NONE;
        if (i_geom.x_zero && i_geom.y_zero) begin
            w_mult = 4'd0;
        end else if (i_geom.x_zero) begin
            w_mult = i_geom.y_neg ? 4'd6 : 4'd2;
        end else if (i_geom.y_zero) begin
            w_mult = i_geom.x_neg ? 4'd4 : 4'd0;
        end else if (!i_geom.x_neg && !i_geom.y_neg) begin
            w_mult = i_geom.ax_gt ? 4'd0 : (i_geom.ax_lt ? 4'd2 : 4'd1);
            w_fop  = i_geom.ax_gt ? FOP_ADD : (i_geom.ax_lt ? FOP_SUB : FOP_NONE);
        end else if (i_geom.x_neg && !i_geom.y_neg) begin
            w_mult = i_geom.ax_gt ? 4'd4 : (i_geom.ax_lt ? 4'd2 : 4'd3);
            w_fop  = i_geom.ax_gt ? FOP_SUB : (i_geom.ax_lt ? FOP_ADD : FOP_NONE);
        end else if (i_geom.x_neg && i_geom.y_neg) begin
            w_mult = i_geom.ax_gt ? 4'd4 : (i_geom.ax_lt ? 4'd6 : 4'd5);
            w_fop  = i_geom.ax_gt ? FOP_ADD : (i_geom.ax_lt ? FOP_SUB : FOP_NONE);
        end else begin
            w_mult = i_geom.ax_gt ? 4'd8 : (i_geom.ax_lt ? 4'd6 : 4'd7);
            w_fop  = i_geom.ax_gt ? FOP_SUB : (i_geom.ax_lt ? FOP_ADD : FOP_NONE);
        end
    end

    assign w_prod = SUM_W'(w_mult) * SUM_W'(i_oct);

    // Add or subtract the ratio term
    always_comb begin
        case (r_fop)
            FOP_ADD: w_sum = r_base + SUM_W'(i_quo);
            FOP_SUB: w_sum = r_base - SUM_W'(i_quo);
            default: w_sum = r_base;
        endcase
    end

    // Half a turn is four octant steps
    assign w_half = {i_oct, 2'b00};

    // Three-stage sequence: base multiple, saturated bearing, heading error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
        if (i_start) begin
            r_base <= w_prod;
            r_fop  <= w_fop;
        end
        if (r_vld[0]) begin
            r_bear <= (w_sum > BEAR_LIM) ? BEAR_LIM[BEAR_W-1:0] : w_sum[BEAR_W-1:0];
        end
        if (r_vld[1]) begin
            r_hgt <= (i_heading > r_bear);
            r_err <= (i_heading > r_bear) ? (i_heading - r_bear) : (r_bear - i_heading);
        end
    end

    // Turn decision; a stop names the last turn
    always_comb begin
        if (r_err > BEAR_W'(i_deadband)) begin
            if (r_hgt || (r_err > w_half)) begin
                o_action = TURN_RIGHT;
            end else begin
                o_action = TURN_LEFT;
            end
        end else begin
            o_action = i_last_turn ? STOP_LEFT : STOP_RIGHT;
        end
    end

    assign o_done    = r_vld[2];
    assign o_bearing = r_bear;

endmodule

`default_nettype wire

// ----- test/octant_heading_steer_core_tb.sv -----
// Self-checking testbench for the octant heading steer core.
`timescale 1ns / 100ps

module octant_heading_steer_core_tb;
    import ohs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 113;
    localparam int HEADING_MAX   = 51471;
    localparam int MAX_REPORTS   = 10;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

    // One position beat: own and target coordinates plus the current heading
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic [15:0]        heading;
    } t_pos;

    // One steering result
    typedef struct packed {
        logic [15:0] bearing;
        t_turn       act;
    } t_steer_cmd;

    // Directed row; known rows carry a hand-computed result
    typedef struct packed {
        t_pos       pos;
        logic       known;
        t_steer_cmd cmd;
    } t_steer_row;

    // Directed rows, run under the reset register values
    localparam t_steer_row STEER_TABLE [25] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b1, '{16'd0, STOP_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd100, 32'sd0, 16'd0}, 1'b1, '{16'd0, STOP_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd5, 16'd0}, 1'b1, '{16'd12780, TURN_LEFT}},
        '{'{32'sd0, 32'sd0, -32'sd7, 32'sd0, 16'd51471}, 1'b1, '{16'd25560, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd0, -32'sd1, 16'd38340}, 1'b1, '{16'd38340, STOP_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd3, 32'sd3, 16'd6390}, 1'b1, '{16'd6390, STOP_RIGHT}},
        '{'{32'sd0, 32'sd0, -32'sd3, 32'sd3, 16'd0}, 1'b1, '{16'd19170, TURN_LEFT}},
        '{'{32'sd0, 32'sd0, -32'sd9, -32'sd9, 16'd31950}, 1'b1, '{16'd31950, STOP_LEFT}},
        '{'{32'sd0, 32'sd0, 32'sd5, -32'sd5, 16'd0}, 1'b1, '{16'd44730, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, -32'sd1, 32'sd0, 16'd0}, 1'b1, '{16'd25560, TURN_LEFT}},
        '{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, 16'd1638}, 1'b1, '{16'd0, STOP_LEFT}},
        '{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, 16'd1639}, 1'b1, '{16'd0, TURN_RIGHT}},
        '{'{C_MIN, C_MIN, C_MAX, C_MAX, 16'd51471}, 1'b1, '{16'd6390, TURN_RIGHT}},
        '{'{C_MAX, C_MIN, C_MIN, C_MAX, 16'd19170}, 1'b1, '{16'd19170, STOP_RIGHT}},
        '{'{C_MAX, C_MAX, C_MIN, C_MIN, 16'd0}, 1'b1, '{16'd31950, TURN_RIGHT}},
        '{'{C_MIN, C_MAX, C_MAX, C_MIN, 16'd44730}, 1'b1, '{16'd44730, STOP_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd3, 32'sd1, 16'd2130}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd1, 32'sd3, 16'd0}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, -32'sd7, 32'sd2, 16'd51471}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, -32'sd2, 32'sd7, 16'd16000}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, -32'sd7, -32'sd2, 16'd0}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, -32'sd2, -32'sd7, 16'd34000}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd7, -32'sd2, 16'd45000}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{32'sd0, 32'sd0, 32'sd2, -32'sd7, 16'd1000}, 1'b0, '{16'd0, TURN_RIGHT}},
        '{'{C_MIN, 32'sd0, C_MAX, 32'sd1, 16'd32767}, 1'b0, '{16'd0, TURN_RIGHT}}
    };

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = CFG_OCTANT;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [143:0]           i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    // Shadow of the block's registers and remembered turn
    logic [OCT_W-1:0] oct_angle_m;
    logic [OCT_W-1:0] deadband_m;
    logic             last_left;

    t_steer_cmd pending_cmds [$];
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         idle_mode   = 0;

    octant_heading_steer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle percentage per side: receiver-heavy, then sender-heavy, then none.
    function automatic int idle_pct(input bit rx_side);
        case (idle_mode)
            0: return rx_side ? 77 : 34;
            1: return rx_side ? 34 : 77;
            default: return 0;
        endcase
    endfunction

    // Octant-linear bearing, saturated to the 16-bit angle range.
    function automatic logic [15:0] octant_bearing(input longint dx, input longint dy,
                                                   input logic [OCT_W-1:0] a_in);
        longint unsigned ax, ay, f, a;
        longint unsigned b;
        a  = a_in;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (dx == 0 && dy == 0) return 16'd0;
        if (dx == 0) b = (dy > 0) ? 2 * a : 6 * a;
        else if (dy == 0) b = (dx > 0) ? 0 : 4 * a;
        else begin
            f = (ax > ay) ? (ay * a) / ax : (ax * a) / ay;
            if (dx > 0 && dy > 0)
                b = (ax > ay) ? f : (ax < ay) ? 2 * a - f : a;
            else if (dx < 0 && dy > 0)
                b = (ax > ay) ? 4 * a - f : (ax < ay) ? 2 * a + f : 3 * a;
            else if (dx < 0)
                b = (ax > ay) ? 4 * a + f : (ax < ay) ? 6 * a - f : 5 * a;
            else
                b = (ax > ay) ? 8 * a - f : (ax < ay) ? 6 * a + f : 7 * a;
        end
        return (b > 65535) ? 16'hFFFF : b[15:0];
    endfunction

    // Bearing plus turn decision; a turn updates the remembered direction.
    task automatic steer_command(input t_pos p, output t_steer_cmd c);
        int err, half;
        c.bearing = octant_bearing(longint'(p.tx) - longint'(p.ox),
                                   longint'(p.ty) - longint'(p.oy), oct_angle_m);
        err  = (p.heading > c.bearing) ? p.heading - c.bearing : c.bearing - p.heading;
        half = 4 * oct_angle_m;
        if (err > deadband_m) begin
            if (p.heading > c.bearing) c.act = TURN_RIGHT;
            else if (err < half) c.act = TURN_LEFT;
            else if (err > half) c.act = TURN_RIGHT;
            else c.act = TURN_LEFT;
            last_left = (c.act == TURN_LEFT);
        end else begin
            c.act = last_left ? STOP_LEFT : STOP_RIGHT;
        end
    endtask

    // Offer one position beat, wait for acceptance, then log what it must produce.
    task automatic send_pos(input t_pos p, input logic known, input t_steer_cmd known_cmd);
        t_steer_cmd predicted;
        while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p.heading, p.ty, p.tx, p.oy, p.ox};
        do @(posedge i_clk); while (!o_s_tready);
        steer_command(p, predicted);
        pending_cmds.push_back(known ? known_cmd : predicted);
    endtask

    // Register write; the shadow copy follows it.
    task automatic write_reg(input t_cfg_idx idx, input logic [OCT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OCTANT) oct_angle_m = value;
        else deadband_m = value;
    endtask

    // Stop offering beats and wait until every result has come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_offset();
        logic signed [31:0] r;
        r = $urandom;
        return r >>> $urandom_range(2, 31);
    endfunction

    // Random beat: mostly nearby targets with axis, tie and same-spot cases,
    // headings often placed near the bearing or half a turn away from it.
    task automatic draw_position(output t_pos p);
        logic signed [31:0] dx, dy;
        logic [15:0] bear;
        int hv;
        case ($urandom_range(0, 15))
            0, 1: begin
                p.ox = $urandom; p.oy = $urandom; p.tx = $urandom; p.ty = $urandom;
            end
            2, 3: begin
                p.ox = pick_extreme(); p.oy = pick_extreme();
                p.tx = pick_extreme(); p.ty = pick_extreme();
            end
            default: begin
                p.ox = $signed($urandom) >>> 1;
                p.oy = $signed($urandom) >>> 1;
                dx = rand_offset();
                dy = rand_offset();
                case ($urandom_range(0, 7))
                    0: dx = 0;
                    1: dy = 0;
                    2: dy = $urandom_range(0, 1) ? dx : -dx;
                    3: if ($urandom_range(0, 3) == 0) begin
                        dx = 0;
                        dy = 0;
                    end
                    default: ;
                endcase
                p.tx = p.ox + dx;
                p.ty = p.oy + dy;
            end
        endcase
        bear = octant_bearing(longint'(p.tx) - longint'(p.ox),
                              longint'(p.ty) - longint'(p.oy), oct_angle_m);
        case ($urandom_range(0, 3))
            0, 1: hv = $urandom_range(0, HEADING_MAX);
            2: hv = int'(bear) + $urandom_range(0, 2 * deadband_m + 4) - deadband_m - 2;
            default: hv = $urandom_range(0, 1) ? bear + 4 * oct_angle_m
                                                : bear - 4 * oct_angle_m;
        endcase
        if (hv < 0) hv = 0;
        if (hv > HEADING_MAX) hv = HEADING_MAX;
        p.heading = 16'(hv);
    endtask

    // Compare a returned beat with the oldest outstanding result.
    task automatic check_cmd(input logic [15:0] got_bear, input logic [1:0] got_act);
        t_steer_cmd want;
        if (pending_cmds.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected output beat: bearing %0d turn %0d", got_bear, got_act);
        end else begin
            want = pending_cmds.pop_front();
            if (got_bear !== want.bearing || got_act !== want.act) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("mismatch: bearing exp %0d got %0d, turn exp %0d got %0d",
                             want.bearing, got_bear, want.act, got_act);
            end
        end
    endtask

    // Output side: check accepted beats and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_cmd(o_m_tdata[15:0], o_m_tdata[17:16]);
        i_m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_pos       p;
        t_steer_cmd none;
        int         oct_set [6];
        int         db_set  [6];
        none = '{16'd0, TURN_RIGHT};
        oct_angle_m = OCT_RESET;
        deadband_m  = DB_RESET;
        last_left   = 1'b0;

        // Register settings per random phase: extremes first, then random.
        oct_set = '{1, 16383, 0, 16383, 0, 0};
        db_set  = '{0, 16383, 300, 0, 0, 0};
        oct_set[4] = $urandom_range(1, 16383);
        oct_set[5] = $urandom_range(1, 16383);
        db_set[4]  = $urandom_range(0, 4000);
        db_set[5]  = $urandom_range(0, 4000);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset register values
        foreach (STEER_TABLE[i])
            send_pos(STEER_TABLE[i].pos, STEER_TABLE[i].known, STEER_TABLE[i].cmd);

        // Random phases; idle pattern changes every two phases
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(CFG_OCTANT, OCT_W'(oct_set[ph]));
            write_reg(CFG_DEADBAND, OCT_W'(db_set[ph]));
            idle_mode = ph / 2;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                draw_position(p);
                send_pos(p, 1'b0, none);
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
